// ===== sv/rfa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared types and constants of the Rastrigin fitness accumulator.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned AmpW   = 16;
  localparam int unsigned TermW  = 31;  // x^2 + A*(1-cos) in Q.24, below 2^31
  localparam int unsigned SumW   = 41;  // unsigned Q17.24
  localparam int unsigned CountW = 11;

  // Largest coordinate count that is still in range.
  localparam logic [CountW:0] MaxDim = 12'd1024;

  typedef struct packed {
    logic [TermW-1:0] term;
    logic             last;
  } rfa_item_t;

  typedef struct packed {
    logic [SumW-1:0]   fitness;
    logic [CountW-1:0] coord_count;
    logic              overflow;
  } rfa_result_t;

endpackage
`default_nettype wire

// ===== sv/rfa_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_front
// Two-stage term pipeline: phase lookup, then both products, then the term.
// ----------------------------------------------------------------------------
module rfa_front import rfa_pkg::*; #(
  parameter int unsigned COS_TABLE_BITS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CoordW-1:0] coord_i,
  input  wire logic              last_i,
  input  wire logic [AmpW-1:0]   amplitude_i,
  output logic                   item_valid_o,
  output rfa_item_t              item_o,
  input  wire logic              item_ready_i
);

  localparam int unsigned QuarterBits = COS_TABLE_BITS - 2;
  localparam int unsigned QSize       = 1 << QuarterBits;
  localparam int unsigned IdxW        = QuarterBits + 1;
  localparam logic [63:0] Q30One      = 64'h0000_0000_4000_0000;
  localparam logic [63:0] HalfPiQ30   = 64'd1686629713;

  function automatic logic [63:0] clip_sub(input logic [63:0] p);
    return (p > Q30One) ? 64'd0 : (Q30One - p);
  endfunction

  // Quarter-wave cosine entry k in Q1.16, Taylor series in Q2.30.
  function automatic logic [16:0] quarter_cos(input int unsigned k,
                                              input int unsigned qbits);
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] b;
    logic [63:0] c;
    theta = (64'(k) * HalfPiQ30) >> qbits;
    t2    = (theta * theta) >> 30;
    b     = Q30One;
    b     = clip_sub(((t2 * b) >> 30) / 64'd182);
    b     = clip_sub(((t2 * b) >> 30) / 64'd132);
    b     = clip_sub(((t2 * b) >> 30) / 64'd90);
    b     = clip_sub(((t2 * b) >> 30) / 64'd56);
    b     = clip_sub(((t2 * b) >> 30) / 64'd30);
    b     = clip_sub(((t2 * b) >> 30) / 64'd12);
    c     = clip_sub(((t2 * b) >> 30) >> 1);
    return 17'((c + 64'd8192) >> 14);
  endfunction

  logic [16:0] cos_tbl [QSize+1];

  for (genvar k = 0; k <= QSize; k++) begin : g_tbl
    localparam logic [16:0] Entry = quarter_cos(k, QuarterBits);
    assign cos_tbl[k] = Entry;
  end

  // Stage A: magnitude and 1 - cos
  logic                    a_valid_q;
  logic [CoordW-1:0]       a_mag_q;
  logic [17:0]             a_omc_q;
  logic                    a_last_q;
  // Stage B: products
  logic                    b_valid_q;
  logic [TermW-1:0]        b_x2_q;
  logic [33:0]             b_ap_q;
  logic                    b_last_q;

  logic                    a_ready;
  logic                    b_ready;
  logic [CoordW-1:0]       mag;
  logic [COS_TABLE_BITS-1:0] phase;
  logic [1:0]              quad;
  logic [QuarterBits-1:0]  rem;
  logic [IdxW-1:0]         idx;
  logic [16:0]             cval;
  logic [17:0]             omc;
  logic [31:0]             sq;
  logic [33:0]             ap;
  logic [33:0]             ap_rnd;

  assign b_ready    = !b_valid_q || item_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // Period is one: the fraction bits alone give the phase.
  assign mag   = coord_i[CoordW-1] ? (~coord_i + 16'd1) : coord_i;
  assign phase = coord_i[11 -: COS_TABLE_BITS];
  assign quad  = phase[COS_TABLE_BITS-1 -: 2];
  assign rem   = phase[QuarterBits-1:0];
  // Odd quadrants mirror the quarter wave.
  assign idx   = quad[0] ? (IdxW'(QSize) - {1'b0, rem}) : {1'b0, rem};
  assign cval  = cos_tbl[idx];
  // Cosine is negative in the second and third quadrants.
  assign omc   = (quad[0] ^ quad[1]) ? (18'd65536 + {1'b0, cval})
                                     : (18'd65536 - {1'b0, cval});

  assign sq     = a_mag_q * a_mag_q;
  assign ap     = amplitude_i * a_omc_q;
  assign ap_rnd = (b_ap_q + 34'd8) >> 4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_mag_q  <= mag;
      a_omc_q  <= omc;
      a_last_q <= last_i;
    end
    if (b_ready && a_valid_q) begin
      b_x2_q   <= sq[TermW-1:0];
      b_ap_q   <= ap;
      b_last_q <= a_last_q;
    end
  end

  assign item_valid_o = b_valid_q;
  assign item_o.term  = b_x2_q + ap_rnd[TermW-1:0];
  assign item_o.last  = b_last_q;

endmodule
`default_nettype wire

// ===== sv/rfa_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_queue
// Small register FIFO of terms between the term pipeline and the accumulator.
// ----------------------------------------------------------------------------
module rfa_queue import rfa_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  output logic           push_ready_o,
  input  wire rfa_item_t push_item_i,
  output logic           pop_valid_o,
  input  wire logic      pop_ready_i,
  output rfa_item_t      pop_item_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  rfa_item_t        mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rfa_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_back
// Saturating accumulator with count and flag, and the result register.
// ----------------------------------------------------------------------------
module rfa_back import rfa_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      item_valid_i,
  output logic           item_ready_o,
  input  wire rfa_item_t item_i,
  output logic           res_valid_o,
  input  wire logic      res_ready_i,
  output rfa_result_t    res_o
);

  logic [SumW-1:0]   sum_q;
  logic [CountW-1:0] count_q;
  logic              sat_q;
  logic              res_valid_q;
  rfa_result_t       res_q;

  logic              out_free;
  logic              take;
  logic [SumW:0]     sum_wide;
  logic [SumW-1:0]   sum_new;
  logic              cnt_full;
  logic [CountW-1:0] cnt_new;
  logic              flag_new;

  assign out_free     = !res_valid_q || res_ready_i;
  // Non-final terms never wait on the output side.
  assign item_ready_o = !item_i.last || out_free;
  assign take         = item_valid_i && item_ready_o;

  assign sum_wide = {1'b0, sum_q} + (SumW + 1)'(item_i.term);
  assign sum_new  = sum_wide[SumW] ? '1 : sum_wide[SumW-1:0];
  assign cnt_full = (count_q == '1);
  assign cnt_new  = cnt_full ? count_q : count_q + 1'b1;
  assign flag_new = sat_q || sum_wide[SumW] || cnt_full || ({1'b0, cnt_new} > MaxDim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      count_q     <= '0;
      sat_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (take && item_i.last) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (take) begin
        if (item_i.last) begin
          sum_q   <= '0;
          count_q <= '0;
          sat_q   <= 1'b0;
        end else begin
          sum_q   <= sum_new;
          count_q <= cnt_new;
          sat_q   <= flag_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.last) begin
      res_q.fitness     <= sum_new;
      res_q.coord_count <= cnt_new;
      res_q.overflow    <= flag_new;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ===== sv/rastrigin_fitness_accumulator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rastrigin_fitness_accumulator
// Streams point coordinates in and returns the Rastrigin value of each point.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat per coordinate, signed Q4.12 in s_axis_tdata[15:0],
//   s_axis_tlast high on the final coordinate of a point.
//   Master stream: one beat per point, fitness (unsigned Q17.24, saturated) in
//   m_axis_tdata[40:0], coordinate count in [51:41], overflow in m_axis_tuser.
//   APB: register 0 at address 0 holds the amplitude A (unsigned Q4.12).
//   Write it only while no point is in flight.
// Timing:
//   One coordinate per cycle sustained while the result stream is not held.
//   The result beat follows the last coordinate's beat through the lookup
//   stage, product stage, term queue and result register.
// Reset:
//   Clears the pipeline, the queue, the sum, count and flag; A returns to 10.0.
// Stalls:
//   A held result beat does not block summing of the next point's coordinates;
//   only its final coordinate waits, the term queue fills, then the slave
//   side drops tready.
// ----------------------------------------------------------------------------
module rastrigin_fitness_accumulator import rfa_pkg::*; #(
  parameter int unsigned COS_TABLE_BITS = 8,
  parameter int unsigned QUEUE_DEPTH    = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // coordinate stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] coord
  input  wire logic        s_axis_tlast,
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // [40:0] fitness, [51:41] coord_count
  output logic             m_axis_tuser,   // [0] overflow
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [AmpW-1:0] AmpReset = 16'd40960;

  logic [AmpW-1:0] amplitude_q;
  logic            amp_sel;

  // Register 0 decodes on the word index bit.
  assign amp_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = amp_sel ? {16'd0, amplitude_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amplitude_q <= AmpReset;
    end else if (psel && penable && pwrite && pready && amp_sel) begin
      amplitude_q <= pwdata[AmpW-1:0];
    end
  end

  logic        f_valid, f_ready;
  rfa_item_t   f_item;
  logic        q_valid, q_ready;
  rfa_item_t   q_item;
  rfa_result_t res;

  rfa_front #(
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .coord_i      (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .amplitude_i  (amplitude_q),
    .item_valid_o (f_valid),
    .item_o       (f_item),
    .item_ready_i (f_ready)
  );

  rfa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  rfa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {4'd0, res.coord_count, res.fitness};
  assign m_axis_tuser = res.overflow;

endmodule
`default_nettype wire
